// File: src/lru_block_cache_directory_defines.svh
// ----------------------------------------------------------------------------
// lru_block_cache_directory_defines
// Assertion macros used by the checker file of the cache directory.
// ----------------------------------------------------------------------------
`ifndef LRU_BLOCK_CACHE_DIRECTORY_DEFINES_SVH
`define LRU_BLOCK_CACHE_DIRECTORY_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCD_ASSERT_IMPL(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cache directory check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LCD_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cache directory check failed");

`endif

// File: src/lcd_pkg.sv
// ----------------------------------------------------------------------------
// lcd_pkg
// Sizes, codes and shared types of the LRU block cache directory.
// ----------------------------------------------------------------------------
`default_nettype none

package lcd_pkg;

	// Directory size and derived widths.
	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	// Field widths.
	localparam int ADDR_W  = 32;
	localparam int STAMP_W = 32;
	localparam int LIMIT_W = 5;
	localparam int SLOT_W  = 4;
	localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

	// Operation codes.
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_INVAL = 1'b1;

	// One compare step of the scan.
	typedef struct packed {
		logic             valid;
		logic             first;
		logic [IDX_W-1:0] idx;
	} scan_req_t;

	// What the scan unit reports back.
	typedef struct packed {
		logic              match;
		logic [IDX_W-1:0]  min_idx;
		logic [ADDR_W-1:0] min_addr;
	} scan_res_t;

endpackage

`default_nettype wire

// File: src/lcd_ram.sv
// ----------------------------------------------------------------------------
// lcd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]      wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: src/lcd_scan.sv
// ----------------------------------------------------------------------------
// lcd_scan
// Shared compare unit: address match and running oldest-stamp search.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_scan import lcd_pkg::*; (
	input  wire logic                clk,
	input  wire scan_req_t           req,
	input  wire logic [ADDR_W-1:0]   key,
	input  wire logic [ADDR_W-1:0]   rd_addr,
	input  wire logic [STAMP_W-1:0]  rd_stamp,
	output scan_res_t                res
);

	logic [STAMP_W-1:0] min_stamp_q;
	logic [IDX_W-1:0]   min_idx_q;
	logic [ADDR_W-1:0]  min_addr_q;
	logic               take;

	// A strictly smaller stamp replaces the minimum, so ties keep the lowest index.
	assign take = req.valid && (req.first || (rd_stamp < min_stamp_q));

	always_ff @(posedge clk) begin
		if (take) begin
			min_stamp_q <= rd_stamp;
			min_idx_q   <= req.idx;
			min_addr_q  <= rd_addr;
		end
	end

	// The match is reported in the cycle the entry is compared.
	assign res.match    = req.valid && (rd_addr == key);
	assign res.min_idx  = min_idx_q;
	assign res.min_addr = min_addr_q;

endmodule

`default_nettype wire

// File: src/lru_block_cache_directory.sv
// ----------------------------------------------------------------------------
// lru_block_cache_directory
// Directory of a fully associative block cache with LRU replacement.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and is stalled until its result
// word is formed. How long a command takes is set by the scan, which reads
// one entry per cycle through the single read port of the address and stamp
// memories and compares it in the shared compare unit. A result word waits
// in an output register, so the next command is taken while the result is
// still stalled. A read reports the slot holding the address, and on a miss
// whether an entry was evicted and that block data must be fetched. An
// invalidate compacts the directory by moving the last entry into the freed
// slot. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_block_cache_directory import lcd_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// Command channel.
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire logic                opcode,
	input  wire logic [ADDR_W-1:0]   block_addr,
	// Result channel.
	output logic                     res_valid,
	input  wire logic                res_stall,
	output logic                     hit,
	output logic      [SLOT_W-1:0]   slot,
	output logic                     fetch_needed,
	output logic                     evicted,
	output logic      [ADDR_W-1:0]   evicted_addr,
	output logic                     removed,
	// Configuration channel.
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [LIMIT_W-1:0]  cfg_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_MOVE   = 3'd3;
	localparam logic [2:0] ST_APPEND = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]         state_q;
	logic               op_q;
	logic [ADDR_W-1:0]  key_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   iss_q;
	logic [STAMP_W-1:0] ctr_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               chk_valid_s1;
	logic [IDX_W-1:0]   chk_idx_s1;
	logic               found_q;
	logic [IDX_W-1:0]   found_idx_q;
	logic [IDX_W-1:0]   dst_q;

	// Result staging while the command is at work.
	logic               r_hit_q;
	logic [IDX_W-1:0]   r_slot_q;
	logic               r_fetch_q;
	logic               r_ev_q;
	logic [ADDR_W-1:0]  r_evaddr_q;
	logic               r_rem_q;

	// Output register.
	logic               res_valid_q;
	logic               hit_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               fetch_q;
	logic               ev_q;
	logic [ADDR_W-1:0]  evaddr_q;
	logic               rem_q;

	logic               accept;
	logic               issue;
	logic               scan_done;
	logic               load_res;
	logic               full;
	logic [IDX_W-1:0]   last_idx;
	logic [CMP_W-1:0]   lim_raw;
	logic [CMP_W-1:0]   lim;
	logic [IDX_W-1:0]   raddr;
	logic [IDX_W-1:0]   waddr;
	logic               addr_we;
	logic               stamp_we;
	logic [ADDR_W-1:0]  addr_wdata;
	logic [STAMP_W-1:0] stamp_wdata;
	logic [ADDR_W-1:0]  rd_addr;
	logic [STAMP_W-1:0] rd_stamp;
	scan_req_t          sreq;
	scan_res_t          sres;

	// Handshakes.
	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign cfg_ready = 1'b1;
	assign load_res  = (state_q == ST_DONE) && (!res_valid_q || !res_stall);

	// Effective limit: zero acts as one, anything above the size as the size.
	assign lim_raw = CMP_W'(limit_q);
	always_comb begin
		lim = lim_raw;
		if (lim_raw == CMP_W'(0)) begin
			lim = CMP_W'(1);
		end else if (lim_raw > CMP_W'(MAX_ENTRIES)) begin
			lim = CMP_W'(MAX_ENTRIES);
		end
	end
	assign full     = (CMP_W'(count_q) >= lim) && (count_q != CNT_W'(0));
	assign last_idx = IDX_W'(count_q - CNT_W'(1));

	// Scan control: one entry read per cycle, each compared in the cycle after its read.
	assign scan_done = chk_valid_s1 && (sres.match || (chk_idx_s1 == last_idx));
	assign issue     = (state_q == ST_SCAN) && (iss_q < count_q) && !scan_done;
	assign raddr     = (state_q == ST_SCAN) ? iss_q[IDX_W-1:0] : last_idx;

	assign sreq.valid = chk_valid_s1;
	assign sreq.first = (chk_idx_s1 == IDX_W'(0));
	assign sreq.idx   = chk_idx_s1;

	// Write port of the entry memories.
	always_comb begin
		addr_we     = 1'b0;
		stamp_we    = 1'b0;
		waddr       = dst_q;
		addr_wdata  = rd_addr;
		stamp_wdata = rd_stamp;
		unique case (state_q)
			ST_DECIDE: begin
				if ((op_q == OP_READ) && found_q) begin
					stamp_we    = 1'b1;
					waddr       = found_idx_q;
					stamp_wdata = ctr_q;
				end
			end
			ST_MOVE: begin
				addr_we  = 1'b1;
				stamp_we = 1'b1;
			end
			ST_APPEND: begin
				addr_we     = 1'b1;
				stamp_we    = 1'b1;
				waddr       = IDX_W'(count_q);
				addr_wdata  = key_q;
				stamp_wdata = ctr_q;
			end
			default: begin
			end
		endcase
	end

	lcd_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (MAX_ENTRIES)
	) u_addr_ram (
		.clk   (clk),
		.we    (addr_we),
		.waddr (waddr),
		.wdata (addr_wdata),
		.raddr (raddr),
		.rdata (rd_addr)
	);

	lcd_ram #(
		.WIDTH (STAMP_W),
		.DEPTH (MAX_ENTRIES)
	) u_stamp_ram (
		.clk   (clk),
		.we    (stamp_we),
		.waddr (waddr),
		.wdata (stamp_wdata),
		.raddr (raddr),
		.rdata (rd_stamp)
	);

	lcd_scan u_scan (
		.clk      (clk),
		.req      (sreq),
		.key      (key_q),
		.rd_addr  (rd_addr),
		.rd_stamp (rd_stamp),
		.res      (sres)
	);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			ctr_q        <= '0;
			limit_q      <= LIMIT_RESET;
			chk_valid_s1 <= 1'b0;
			found_q      <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			chk_valid_s1 <= issue;
			// A new result word replaces the one leaving in the same cycle.
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						if (opcode == OP_READ) begin
							ctr_q <= ctr_q + STAMP_W'(1);
						end
						state_q <= (count_q == CNT_W'(0)) ? ST_DECIDE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (chk_valid_s1 && sres.match) begin
						found_q <= 1'b1;
					end
					if (scan_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (op_q == OP_INVAL) begin
						state_q <= found_q ? ST_MOVE : ST_DONE;
					end else if (found_q) begin
						state_q <= ST_DONE;
					end else if (full) begin
						state_q <= ST_MOVE;
					end else begin
						state_q <= ST_APPEND;
					end
				end
				ST_MOVE: begin
					count_q <= count_q - CNT_W'(1);
					state_q <= (op_q == OP_INVAL) ? ST_DONE : ST_APPEND;
				end
				ST_APPEND: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_res) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command payload, scan indexes and result staging.
	always_ff @(posedge clk) begin
		chk_idx_s1 <= iss_q[IDX_W-1:0];
		if (accept) begin
			op_q       <= opcode;
			key_q      <= block_addr;
			iss_q      <= '0;
			r_hit_q    <= 1'b0;
			r_slot_q   <= '0;
			r_fetch_q  <= 1'b0;
			r_ev_q     <= 1'b0;
			r_evaddr_q <= '0;
			r_rem_q    <= 1'b0;
		end
		if (issue) begin
			iss_q <= iss_q + CNT_W'(1);
		end
		if ((state_q == ST_SCAN) && chk_valid_s1 && sres.match) begin
			found_idx_q <= chk_idx_s1;
		end
		if (state_q == ST_DECIDE) begin
			if (op_q == OP_INVAL) begin
				if (found_q) begin
					dst_q   <= found_idx_q;
					r_hit_q <= 1'b1;
					r_rem_q <= 1'b1;
				end
			end else if (found_q) begin
				r_hit_q  <= 1'b1;
				r_slot_q <= found_idx_q;
			end else if (full) begin
				dst_q      <= sres.min_idx;
				r_ev_q     <= 1'b1;
				r_evaddr_q <= sres.min_addr;
			end
		end
		if (state_q == ST_APPEND) begin
			r_slot_q  <= IDX_W'(count_q);
			r_fetch_q <= 1'b1;
		end
		if (load_res) begin
			hit_q    <= r_hit_q;
			slot_q   <= SLOT_W'(r_slot_q);
			fetch_q  <= r_fetch_q;
			ev_q     <= r_ev_q;
			evaddr_q <= r_evaddr_q;
			rem_q    <= r_rem_q;
		end
	end

	// Result word.
	assign res_valid    = res_valid_q;
	assign hit          = hit_q;
	assign slot         = slot_q;
	assign fetch_needed = fetch_q;
	assign evicted      = ev_q;
	assign evicted_addr = evaddr_q;
	assign removed      = rem_q;

endmodule

`default_nettype wire

// File: src/lcd_checker.sv
// ----------------------------------------------------------------------------
// lcd_checker
// Port-level checks of the cache directory, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_block_cache_directory_defines.svh"

module lcd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cmd_valid,
	input wire logic        cmd_stall,
	input wire logic        res_valid,
	input wire logic        res_stall,
	input wire logic        hit,
	input wire logic [3:0]  slot,
	input wire logic        fetch_needed,
	input wire logic        evicted,
	input wire logic [31:0] evicted_addr,
	input wire logic        removed
);

	// A taken command word keeps the block busy in the next cycle.
	`LCD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, cmd_valid && !cmd_stall, cmd_stall)

	// A stalled result word stays valid and keeps its hit, slot, evicted address and removed fields.
	`LCD_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(hit) && $stable(slot) && $stable(evicted_addr) && $stable(removed))

	// An eviction only happens on a read miss.
	`LCD_ASSERT_IMPL(a_evict_on_miss, clk, arst_n, res_valid && evicted, fetch_needed && !hit && !removed)

	// A removal reports a hit with the read fields cleared.
	`LCD_ASSERT_IMPL(a_remove_fields, clk, arst_n, res_valid && removed, hit && !fetch_needed && !evicted && (slot == 4'd0) && (evicted_addr == 32'd0))

endmodule

bind lru_block_cache_directory lcd_checker u_lcd_checker (.*);

`default_nettype wire

// File: tb/sv/lru_block_cache_directory_tb.sv
// ----------------------------------------------------------------------------
// lru_block_cache_directory_tb
// Self-checking bench for the LRU block cache directory. A directory tracker
// mirrors the entries, their stamps and the access counter. For every
// accepted command word it computes the result word and queues it. Each
// accepted result word is then compared field by field with the oldest
// queued one. Commands are sent in random bursts while the result side
// stalls on its own pattern. The entry limit is changed between phases,
// and the phases include values out of range and limits below the count.
// ----------------------------------------------------------------------------

module lru_block_cache_directory_tb;
	import lcd_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 11;
	localparam int SETTLE_CYCLES  = 30;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 153;
	localparam int POOL_MAX       = 24;

	// One result word as the directory reports it.
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              fetch_needed;
		logic              evicted;
		logic [ADDR_W-1:0] evicted_addr;
		logic              removed;
	} dir_result_t;

	// Mirror of the directory contents and the queue of result words it predicts.
	class directory_tracker;
		logic [ADDR_W-1:0]  entry_addr [MAX_ENTRIES];
		logic [STAMP_W-1:0] entry_stamp [MAX_ENTRIES];
		int                 entry_count;
		logic [STAMP_W-1:0] access_count;
		logic [LIMIT_W-1:0] entry_limit;
		dir_result_t        expected_words [$];
		int                 mismatches;

		function new();
			entry_count  = 0;
			access_count = '0;
			entry_limit  = LIMIT_RESET;
			mismatches   = 0;
		endfunction

		function void set_limit(logic [LIMIT_W-1:0] value);
			entry_limit = value;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		// Compacting removal: the last entry moves into the freed slot.
		function void remove_at(int idx);
			entry_addr[idx]  = entry_addr[entry_count - 1];
			entry_stamp[idx] = entry_stamp[entry_count - 1];
			entry_count--;
		endfunction

		// Work out the result word of one accepted command word.
		function void note_command(logic op, logic [ADDR_W-1:0] addr);
			dir_result_t res;
			int          found;
			int          oldest;
			int          lim;
			res   = '0;
			found = -1;
			for (int i = 0; i < entry_count; i++) begin
				if (found < 0 && entry_addr[i] == addr)
					found = i;
			end
			if (op == OP_INVAL) begin
				if (found >= 0) begin
					remove_at(found);
					res.hit     = 1'b1;
					res.removed = 1'b1;
				end
			end else begin
				access_count = access_count + 1'b1;
				if (found >= 0) begin
					entry_stamp[found] = access_count;
					res.hit  = 1'b1;
					res.slot = SLOT_W'(found);
				end else begin
					// A limit of zero acts as one, anything above the size as the size.
					lim = int'(entry_limit);
					if (lim < 1)
						lim = 1;
					if (lim > MAX_ENTRIES)
						lim = MAX_ENTRIES;
					if (entry_count >= lim && entry_count > 0) begin
						oldest = 0;
						for (int i = 1; i < entry_count; i++) begin
							if (entry_stamp[i] < entry_stamp[oldest])
								oldest = i;
						end
						res.evicted      = 1'b1;
						res.evicted_addr = entry_addr[oldest];
						remove_at(oldest);
					end
					if (entry_count < MAX_ENTRIES) begin
						entry_addr[entry_count]  = addr;
						entry_stamp[entry_count] = access_count;
						res.slot = SLOT_W'(entry_count);
						entry_count++;
					end
					res.fetch_needed = 1'b1;
				end
			end
			expected_words.push_back(res);
		endfunction

		function void compare_field(string name, logic [ADDR_W-1:0] exp_v,
			logic [ADDR_W-1:0] act_v);
			if (exp_v !== act_v) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, name, exp_v, act_v);
			end
		endfunction

		// Compare one accepted result word with the oldest prediction.
		function void check_result(dir_result_t act);
			dir_result_t exp_w;
			if (expected_words.size() == 0) begin
				mismatches++;
				$display("%0t: result word with none expected, expected none, actual %0h",
					$time, act);
				return;
			end
			exp_w = expected_words.pop_front();
			compare_field("hit", exp_w.hit, act.hit);
			compare_field("slot", exp_w.slot, act.slot);
			compare_field("fetch_needed", exp_w.fetch_needed, act.fetch_needed);
			compare_field("evicted", exp_w.evicted, act.evicted);
			compare_field("evicted_addr", exp_w.evicted_addr, act.evicted_addr);
			compare_field("removed", exp_w.removed, act.removed);
		endfunction
	endclass

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              cmd_valid    = 1'b0;
	logic              cmd_stall;
	logic              opcode       = OP_READ;
	logic [ADDR_W-1:0] block_addr   = '0;
	logic              res_valid;
	logic              res_stall    = 1'b0;
	logic              hit;
	logic [SLOT_W-1:0] slot;
	logic              fetch_needed;
	logic              evicted;
	logic [ADDR_W-1:0] evicted_addr;
	logic              removed;
	logic              cfg_valid    = 1'b0;
	logic              cfg_ready;
	logic [LIMIT_W-1:0] cfg_data    = '0;

	directory_tracker  dir_track    = new();
	int                idle_cycles  = 0;
	int                stall_mode   = 0;
	int                gap_max      = 0;
	int                burst_left   = 0;
	logic [ADDR_W-1:0] addr_pool [POOL_MAX];
	int                pool_size    = 1;

	lru_block_cache_directory DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.opcode       (opcode),
		.block_addr   (block_addr),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.hit          (hit),
		.slot         (slot),
		.fetch_needed (fetch_needed),
		.evicted      (evicted),
		.evicted_addr (evicted_addr),
		.removed      (removed),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// Clock.
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Handshakes are sampled at the falling edge, where everything has settled.
	// A word seen here is taken at the next rising edge.
	always @(negedge clk) begin
		if (cmd_valid && !cmd_stall)
			dir_track.note_command(opcode, block_addr);
		if (res_valid && !res_stall)
			dir_track.check_result('{hit, slot, fetch_needed, evicted, evicted_addr, removed});
		if (cfg_valid && cfg_ready)
			dir_track.set_limit(cfg_data);
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
	end

	// Watchdog on cycles without any word moving.
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(negedge clk);
		$display("FAIL");
		$finish;
	end

	// Result side: alternating free and stalled runs, their mix set per phase.
	initial begin : res_stall_pattern
		int run_left;
		bit stalling;
		run_left = 0;
		stalling = 1'b0;
		forever begin
			@(posedge clk);
			if (run_left <= 0) begin
				if (stall_mode == 0) begin
					stalling = 1'b0;
					run_left = 1;
				end else begin
					stalling = !stalling &&
						($urandom_range(0, 99) < ((stall_mode == 1) ? 30 : 70));
					if (stalling)
						run_left = $urandom_range(1, (stall_mode == 1) ? 3 : 12);
					else
						run_left = $urandom_range(1, 8);
				end
			end
			res_stall <= stalling;
			run_left--;
		end
	end

	// Send one command word; a new burst starts after a random gap.
	task automatic send_command(input logic op, input logic [ADDR_W-1:0] addr);
		int gap;
		if (burst_left <= 0) begin
			gap        = $urandom_range(0, gap_max);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		cmd_valid  <= 1'b1;
		opcode     <= op;
		block_addr <= addr;
		do @(negedge clk); while (cmd_stall);
		@(posedge clk);
		burst_left--;
	endtask

	// Drop valid after the last word of a stretch.
	task automatic end_burst();
		cmd_valid  <= 1'b0;
		burst_left = 0;
	endtask

	// Change the entry limit once the directory has gone idle.
	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		end_burst();
		while (dir_track.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Fresh set of addresses for a phase, with some extreme bit patterns.
	task automatic build_pool(input int size);
		int pick;
		pool_size = size;
		for (int i = 0; i < size; i++) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: addr_pool[i] = '0;
				1: addr_pool[i] = '1;
				2: addr_pool[i] = ADDR_W'(1) << $urandom_range(0, ADDR_W - 1);
				3: addr_pool[i] = ~(ADDR_W'(1) << $urandom_range(0, ADDR_W - 1));
				default: addr_pool[i] = $urandom;
			endcase
		end
	endtask

	// Main sequence.
	initial begin : main_sequence
		int phase_limit [PHASES];
		int lim_value;
		int sel;
		phase_limit = '{16, 3, 31, 0, 7, 16, 1, 17, -1, 15};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part under the reset limit: hits, misses, invalidates,
		// extreme addresses and an invalidate on an empty directory.
		send_command(OP_READ, '0);
		send_command(OP_READ, '1);
		send_command(OP_READ, '0);
		send_command(OP_INVAL, '1);
		send_command(OP_INVAL, '1);
		send_command(OP_INVAL, '0);
		send_command(OP_INVAL, '0);
		send_command(OP_READ, 32'h8000_0000);
		send_command(OP_READ, 32'h0000_0001);

		// Small limit: the oldest stamp is evicted, a refreshed entry survives.
		write_limit(LIMIT_W'(2));
		send_command(OP_READ, 32'h1234_5678);
		send_command(OP_READ, 32'h0000_0001);
		send_command(OP_READ, 32'hA5A5_A5A5);

		// Zero acts as one, and the count stays above the limit.
		write_limit(LIMIT_W'(0));
		send_command(OP_READ, 32'h5A5A_5A5A);
		send_command(OP_READ, 32'h5A5A_5A5A);
		send_command(OP_INVAL, 32'hA5A5_A5A5);
		send_command(OP_READ, 32'h0F0F_F0F0);

		// Above the directory size acts as the size.
		write_limit(LIMIT_W'(31));
		send_command(OP_READ, 32'hFFFF_0000);
		send_command(OP_READ, 32'h0000_FFFF);
		send_command(OP_READ, 32'h5A5A_5A5A);

		// Random phases, each with its own limit, address set and idling.
		for (int p = 0; p < PHASES; p++) begin
			lim_value = (phase_limit[p] < 0) ? $urandom_range(0, 31) : phase_limit[p];
			write_limit(LIMIT_W'(lim_value));
			stall_mode = p % 3;
			gap_max    = ((p % 4) == 3) ? 0 : 6;
			build_pool($urandom_range(2, 20));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 65)
					send_command(OP_READ, addr_pool[$urandom_range(0, pool_size - 1)]);
				else if (sel < 77)
					send_command(OP_READ, $urandom);
				else if (sel < 95)
					send_command(OP_INVAL, addr_pool[$urandom_range(0, pool_size - 1)]);
				else
					send_command(OP_INVAL, $urandom);
			end
		end

		// Drain and let the last word settle.
		end_burst();
		while (dir_track.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (dir_track.mismatches == 0 && dir_track.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/lcd_pkg.sv
src/lcd_ram.sv
src/lcd_scan.sv
src/lru_block_cache_directory.sv
src/lcd_checker.sv
tb/sv/lru_block_cache_directory_tb.sv
